[rtl/post_header_canonical_checker_core_assert.svh]
// Assertion macros used by the core module of the header checker.
`ifndef POST_HEADER_CANONICAL_CHECKER_CORE_ASSERT_SVH
`define POST_HEADER_CANONICAL_CHECKER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PHCC_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("phcc: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define PHCC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("phcc: next-cycle check failed");

`endif

[rtl/phcc_pkg.sv]
package phcc_pkg;

  // Parsing phase of the header scan.
  typedef enum logic [2:0] {
    PH_MAGIC  = 3'd0,
    PH_SPACE  = 3'd1,
    PH_NAME1  = 3'd2,
    PH_NAME2  = 3'd3,
    PH_VALUE1 = 3'd4,
    PH_VALUE  = 3'd5
  } phase_t;

  localparam int KNOWN_COUNT = 5;

  typedef logic [2:0] known_idx_t;

  localparam known_idx_t IDX_UNKNOWN = known_idx_t'(KNOWN_COUNT);
  localparam logic [2:0] MAGIC_LEN = 3'd4;
  localparam logic [31:0] MAGIC_WORD = 32'h4942_4230;  // "IBB0"
  localparam logic [7:0] SPACE_CHAR = 8'h20;

  // Known names in their required order: ID, PA, SJ, DA, RT.
  localparam logic [15:0] KNOWN_NAMES [KNOWN_COUNT] = '{
    16'h4944, 16'h5041, 16'h534A, 16'h4441, 16'h5254
  };

  typedef struct packed {
    phase_t                   phase;
    logic [2:0]               magic_pos;
    logic [7:0]               name_first;
    logic [KNOWN_COUNT-1:0]   known_mask;
    known_idx_t               high_idx;
    logic                     unknown_seen;
    logic                     form_failed;
    logic                     magic_failed;
  } phcc_state_t;

  localparam phcc_state_t STATE_RESET = '{
    phase:        PH_MAGIC,
    magic_pos:    3'd0,
    name_first:   8'd0,
    known_mask:   '0,
    high_idx:     '0,
    unknown_seen: 1'b0,
    form_failed:  1'b0,
    magic_failed: 1'b0
  };

  // Expected magic byte at a given position, first byte in the top bits.
  function automatic logic [7:0] magic_byte(input logic [1:0] pos);
    magic_byte = MAGIC_WORD[(3 - int'(pos)) * 8 +: 8];
  endfunction

  // Index of a known two-character name, or IDX_UNKNOWN.
  function automatic known_idx_t lookup_name(input logic [7:0] a, input logic [7:0] b);
    known_idx_t idx;
    idx = IDX_UNKNOWN;
    for (int i = 0; i < KNOWN_COUNT; i++) begin
      if (idx == IDX_UNKNOWN && KNOWN_NAMES[i] == {a, b}) begin
        idx = known_idx_t'(i);
      end
    end
    return idx;
  endfunction

endpackage

[rtl/phcc_in_if.sv]
interface phcc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] header_byte;
  logic       last_byte;

  modport source (output valid, output header_byte, output last_byte, input ready);
  modport sink   (input valid, input header_byte, input last_byte, output ready);
endinterface

[rtl/phcc_out_if.sv]
interface phcc_out_if;
  logic valid;
  logic ready;
  logic is_canonical;
  logic magic_ok;

  modport source (output valid, output is_canonical, output magic_ok, input ready);
  modport sink   (input valid, input is_canonical, input magic_ok, output ready);
endinterface

[rtl/phcc_step.sv]
// One byte of the header scan: next state and the verdicts for a final byte.
module phcc_step import phcc_pkg::*; (
  input  phcc_state_t st,
  input  logic [7:0]  header_byte,
  input  logic        last_byte,
  output phcc_state_t st_nxt,
  output logic        is_canonical,
  output logic        magic_ok
);

  phcc_state_t upd;
  known_idx_t  idx;

  assign idx = lookup_name(st.name_first, header_byte);

  always_comb begin
    upd = st;
    case (st.phase)
      PH_MAGIC: begin
        if (header_byte != magic_byte(st.magic_pos[1:0])) begin
          upd.magic_failed = 1'b1;
        end
        upd.magic_pos = st.magic_pos + 3'd1;
        if (upd.magic_pos >= MAGIC_LEN) begin
          upd.phase = PH_SPACE;
        end
      end
      PH_SPACE: begin
        if (header_byte != SPACE_CHAR) begin
          upd.form_failed = 1'b1;
        end
        upd.phase = PH_NAME1;
      end
      PH_NAME1: begin
        if (header_byte == SPACE_CHAR) begin
          upd.form_failed = 1'b1;
        end
        upd.name_first = header_byte;
        upd.phase      = PH_NAME2;
      end
      PH_NAME2: begin
        if (idx == IDX_UNKNOWN) begin
          upd.unknown_seen = 1'b1;
        end else if (st.unknown_seen || st.known_mask[idx] || idx < st.high_idx) begin
          upd.form_failed = 1'b1;
        end else begin
          upd.known_mask[idx] = 1'b1;
          upd.high_idx        = idx;
        end
        upd.phase = (header_byte == SPACE_CHAR) ? PH_NAME1 : PH_VALUE1;
      end
      PH_VALUE1: begin
        if (header_byte == SPACE_CHAR) begin
          upd.form_failed = 1'b1;
        end
        upd.phase = PH_VALUE;
      end
      PH_VALUE: begin
        if (header_byte == SPACE_CHAR) begin
          upd.phase = PH_NAME1;
        end
      end
      default: begin
        upd.form_failed = 1'b1;
        upd.phase       = PH_VALUE;
      end
    endcase
  end

  // A header counts as canonical if it ends within or right after the magic, or inside a non-empty value.
  assign is_canonical = !upd.form_failed && upd.phase != PH_NAME1 &&
                        upd.phase != PH_NAME2 && upd.phase != PH_VALUE1;
  assign magic_ok     = !upd.magic_failed && upd.magic_pos >= MAGIC_LEN;

  // The final byte of a header returns the scan to its starting state.
  assign st_nxt = last_byte ? STATE_RESET : upd;

endmodule

[rtl/post_header_canonical_checker_core.sv]
// A final byte passes through the input register, and its verdict is loaded into the result register.
// Throughput: one byte per clock unless a final byte is held up; a result is produced only for a byte marked last.
// Only a last byte waits for the result register, so other bytes keep flowing under stall.
// Reset (rst_n low, synchronous) empties both registers and returns the scan to the magic phase.
// Each header starts fresh: the state clears itself after the final byte of a header.
`include "post_header_canonical_checker_core_assert.svh"

module post_header_canonical_checker_core import phcc_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  phcc_in_if.sink   in_ch,
  phcc_out_if.source out_ch
);

  // Input register: one byte with its last flag, waiting to be scanned.
  logic        s1_valid_r;
  logic [7:0]  s1_byte_r;
  logic        s1_last_r;

  // Scan state carried from byte to byte within one header.
  phcc_state_t st_r;
  phcc_state_t st_nxt;

  // Result register.
  logic        out_valid_r;
  logic        out_canon_r;
  logic        out_magic_r;

  logic        res_canon;
  logic        res_magic;
  logic        s1_go;
  logic        in_ready;

  // The held byte is scanned now unless it is a final byte and the result
  // register still holds an earlier verdict that is not being taken.
  assign s1_go    = s1_valid_r && (!s1_last_r || !out_valid_r || out_ch.ready);
  assign in_ready = !s1_valid_r || s1_go;

  assign in_ch.ready         = in_ready;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.is_canonical = out_canon_r;
  assign out_ch.magic_ok     = out_magic_r;

  // All of the per-byte decisions sit between the input register and the
  // state and result registers.
  phcc_step u_step (
    .st           (st_r),
    .header_byte  (s1_byte_r),
    .last_byte    (s1_last_r),
    .st_nxt       (st_nxt),
    .is_canonical (res_canon),
    .magic_ok     (res_magic)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= STATE_RESET;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_ch.valid;
      end
      if (s1_go) begin
        st_r <= st_nxt;
      end
      if (s1_go && s1_last_r) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers load on their handshakes and need no reset.
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ready) begin
      s1_byte_r <= in_ch.header_byte;
      s1_last_r <= in_ch.last_byte;
    end
    if (s1_go && s1_last_r) begin
      out_canon_r <= res_canon;
      out_magic_r <= res_magic;
    end
  end

  // A scanned final byte always leaves a verdict in the result register.
  `PHCC_ASSERT_NEXT(a_last_gives_result, clk, rst_n, s1_go && s1_last_r, out_valid_r)

  // After a final byte the scan is back at the start of the magic.
  `PHCC_ASSERT_NEXT(a_last_clears_state, clk, rst_n, s1_go && s1_last_r,
                    st_r.phase == PH_MAGIC && st_r.magic_pos == 3'd0)

  // Past the magic phase the full magic has been counted, never more.
  `PHCC_ASSERT_SAME(a_magic_count, clk, rst_n, st_r.phase != PH_MAGIC,
                    st_r.magic_pos == MAGIC_LEN)

  // The input side only stalls behind a final byte blocked by an untaken result.
  `PHCC_ASSERT_SAME(a_stall_cause, clk, rst_n, !in_ready,
                    s1_valid_r && s1_last_r && out_valid_r && !out_ch.ready)

endmodule

[tb/post_header_canonical_checker_core_test.sv]
// Bench for the post header canonical checker.
// Header lines are fed one byte per item, and the final byte carries the last flag.
// An in-bench model of the scan predicts one verdict per header, and each verdict
// that leaves the block is compared with the oldest prediction.
module post_header_canonical_checker_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import phcc_pkg::*;

  localparam int RANDOM_BYTES = 520;
  localparam int HOLD_CYCLES  = 250;
  localparam int CYCLE_LIMIT  = 300000;

  // Scoreboard: it tracks the scan of the current header and keeps the verdicts
  // that are still owed by the block, oldest first.
  class header_verdict_board;
    typedef struct packed {
      logic canonical;
      logic magic_ok;
    } verdict_t;

    phase_t                 scan_phase;
    logic [2:0]             magic_count;
    logic [7:0]             name_head;
    logic [KNOWN_COUNT-1:0] known_seen;
    logic [2:0]             latest_known;
    logic                   unknown_name_seen;
    logic                   form_broken;
    logic                   magic_broken;

    verdict_t expected_verdicts[$];
    int mismatches;
    int verdicts_checked;
    int canonical_count;
    int magic_ok_count;

    function new();
      restart_scan();
      mismatches       = 0;
      verdicts_checked = 0;
      canonical_count  = 0;
      magic_ok_count   = 0;
    endfunction

    function void restart_scan();
      scan_phase        = PH_MAGIC;
      magic_count       = 3'd0;
      name_head         = 8'd0;
      known_seen        = '0;
      latest_known      = 3'd0;
      unknown_name_seen = 1'b0;
      form_broken       = 1'b0;
      magic_broken      = 1'b0;
    endfunction

    // Advance the scan by one accepted byte; a last byte produces a verdict.
    function void note_byte(logic [7:0] b, logic is_last);
      int name_idx;
      verdict_t v;
      case (scan_phase)
        PH_MAGIC: begin
          if (b != MAGIC_WORD[8 * (3 - int'(magic_count[1:0])) +: 8]) magic_broken = 1'b1;
          magic_count = magic_count + 3'd1;
          if (magic_count >= MAGIC_LEN) scan_phase = PH_SPACE;
        end
        PH_SPACE: begin
          if (b != SPACE_CHAR) form_broken = 1'b1;
          scan_phase = PH_NAME1;
        end
        PH_NAME1: begin
          if (b == SPACE_CHAR) form_broken = 1'b1;
          name_head  = b;
          scan_phase = PH_NAME2;
        end
        PH_NAME2: begin
          name_idx = KNOWN_COUNT;
          for (int k = KNOWN_COUNT - 1; k >= 0; k--) begin
            if (KNOWN_NAMES[k] == {name_head, b}) name_idx = k;
          end
          if (name_idx == KNOWN_COUNT) begin
            unknown_name_seen = 1'b1;
          end else if (unknown_name_seen || known_seen[name_idx] ||
                       name_idx < int'(latest_known)) begin
            form_broken = 1'b1;
          end else begin
            known_seen[name_idx] = 1'b1;
            latest_known         = 3'(name_idx);
          end
          // A space in the second name slot already opens the next parameter.
          scan_phase = (b == SPACE_CHAR) ? PH_NAME1 : PH_VALUE1;
        end
        PH_VALUE1: begin
          if (b == SPACE_CHAR) form_broken = 1'b1;
          scan_phase = PH_VALUE;
        end
        PH_VALUE: begin
          if (b == SPACE_CHAR) scan_phase = PH_NAME1;
        end
        default: begin
          form_broken = 1'b1;
          scan_phase  = PH_VALUE;
        end
      endcase
      if (is_last) begin
        v.canonical = !form_broken && !(scan_phase inside {PH_NAME1, PH_NAME2, PH_VALUE1});
        v.magic_ok  = !magic_broken && magic_count >= MAGIC_LEN;
        expected_verdicts.push_back(v);
        restart_scan();
      end
    endfunction

    function void check_verdict(logic canonical, logic magic_ok);
      verdict_t want;
      if (expected_verdicts.size() == 0) begin
        $display("%0t: verdict canonical=%0b magic_ok=%0b arrived with no header pending",
                 $time, canonical, magic_ok);
        mismatches++;
        return;
      end
      want = expected_verdicts.pop_front();
      verdicts_checked++;
      if (want.canonical) canonical_count++;
      if (want.magic_ok) magic_ok_count++;
      if (want.canonical !== canonical) begin
        $display("%0t: is_canonical mismatch, expected %0b, actual %0b",
                 $time, want.canonical, canonical);
        mismatches++;
      end
      if (want.magic_ok !== magic_ok) begin
        $display("%0t: magic_ok mismatch, expected %0b, actual %0b",
                 $time, want.magic_ok, magic_ok);
        mismatches++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  phcc_in_if  in_ch();
  phcc_out_if out_ch();

  post_header_canonical_checker_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  header_verdict_board board;

  // The header under construction, sent as one run of items.
  logic [7:0] line_q[$];

  int bytes_sent;
  int headers_sent;
  int cycle_count;
  // While quiet is set neither side inserts idle cycles.
  bit quiet;
  // The receiver raises ready again only after it has held off for HOLD_CYCLES.
  bit hold_request;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: ready changes on the falling edge. Besides random stalls it
  // holds off once for a long stretch, so the result register stays full and
  // the next last byte of a header is refused at the input.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 0;
      end else begin
        out_ch.ready <= quiet || ($urandom_range(99) >= 20);
      end
    end
  end

  // Both channels are observed at the rising edge, where an item moves when
  // valid and ready are both high.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        board.check_verdict(out_ch.is_canonical, out_ch.magic_ok);
      end
      if (in_ch.valid && in_ch.ready) board.note_byte(in_ch.header_byte, in_ch.last_byte);
    end
  end

  // Watchdog: a hang in either handshake ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d verdicts outstanding",
               cycle_count, board.expected_verdicts.size());
      $display("FAIL post_header_canonical_checker_core");
      $finish;
    end
  end

  // Offers one byte, starting and ending at a falling edge. Random idle
  // cycles come before the byte unless the quiet stretch is on.
  task automatic send_byte(input logic [7:0] b, input logic is_last);
    while (!quiet && $urandom_range(99) < 20) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.header_byte <= b;
    in_ch.last_byte   <= is_last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_line();
    foreach (line_q[i]) send_byte(line_q[i], i == line_q.size() - 1);
    bytes_sent += line_q.size();
    headers_sent++;
  endtask

  function automatic void append_text(string s);
    for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
  endfunction

  task automatic send_text(string s);
    line_q.delete();
    append_text(s);
    send_line();
  endtask

  // Any byte but a space, so that value and name characters stay in place.
  function automatic logic [7:0] rand_nonspace();
    logic [7:0] c;
    c = 8'($urandom_range(255));
    if (c == SPACE_CHAR) c = 8'hA0;
    return c;
  endfunction

  // Builds one random header into line_q. Most headers carry the magic and
  // a parameter list in canonical order with random values; a share of them
  // get one defect, and the rest are raw noise or cut inside the magic.
  function automatic void build_random_line();
    logic [15:0] names[$];
    logic [15:0] held;
    int kind;
    int mutation;
    int pick;
    int vlen;
    int cut;
    line_q.delete();
    kind = $urandom_range(99);
    if (kind < 10) begin
      repeat ($urandom_range(1, 10)) line_q.push_back(8'($urandom_range(255)));
      return;
    end
    if (kind < 16) begin
      cut = $urandom_range(1, 3);
      for (int i = 0; i < cut; i++) begin
        line_q.push_back(($urandom_range(3) == 0) ? 8'($urandom_range(255))
                                                  : MAGIC_WORD[8 * (3 - i) +: 8]);
      end
      return;
    end
    for (int i = 0; i < 4; i++) line_q.push_back(MAGIC_WORD[8 * (3 - i) +: 8]);
    if ($urandom_range(19) == 0) line_q[$urandom_range(3)] = 8'($urandom_range(255));

    // Known names in order, then unknown ones after them.
    for (int k = 0; k < KNOWN_COUNT; k++) begin
      if ($urandom_range(1) == 1) names.push_back(KNOWN_NAMES[k]);
    end
    repeat ($urandom_range(2)) names.push_back({rand_nonspace(), rand_nonspace()});

    mutation = $urandom_range(19);
    case (mutation)
      0: begin
        // Two neighbors swapped, which can put a known name out of order.
        if (names.size() >= 2) begin
          pick            = $urandom_range(names.size() - 2);
          held            = names[pick];
          names[pick]     = names[pick + 1];
          names[pick + 1] = held;
        end
      end
      1: begin
        if (names.size() > 0) names.push_back(names[$urandom_range(names.size() - 1)]);
      end
      2: names.push_front({rand_nonspace(), rand_nonspace()});
      default: ;
    endcase

    pick = (names.size() == 0) ? 0 : $urandom_range(names.size() - 1);
    foreach (names[i]) begin
      // A lone name character followed by a space: that space begins the
      // parameter that follows.
      if (mutation == 5 && i == pick) begin
        line_q.push_back(SPACE_CHAR);
        line_q.push_back(rand_nonspace());
      end
      if (mutation == 3 && i == pick) line_q.push_back(rand_nonspace());
      else line_q.push_back(SPACE_CHAR);
      if (mutation == 4 && i == pick) line_q.push_back(SPACE_CHAR);
      line_q.push_back(names[i][15:8]);
      line_q.push_back(names[i][7:0]);
      vlen = (mutation == 6 && i == pick) ? 0 : $urandom_range(1, 4);
      repeat (vlen) line_q.push_back(rand_nonspace());
    end

    if (mutation == 7) begin
      cut = $urandom_range(1, line_q.size());
      while (line_q.size() > cut) void'(line_q.pop_back());
    end
  endfunction

  initial begin
    int random_start;
    bit hold_done;
    board           = new();
    rst_n           <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.header_byte <= 8'd0;
    in_ch.last_byte   <= 1'b0;
    quiet           = 0;
    hold_request    = 0;
    hold_done       = 0;
    bytes_sent      = 0;
    headers_sent    = 0;
    cycle_count     = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed headers. A single all-ones byte is a header far too short
    // for the magic.
    line_q.delete();
    line_q.push_back(8'hFF);
    send_line();
    send_text("IB");
    send_text("IBB0");
    send_text("IBB0 ID1 PA2 SJ3 DA4 RT5");
    // Headers that end after a space, after one name character, after a name.
    send_text("IBB0 ");
    send_text("IBB0 I");
    send_text("IBB0 ZZ");
    // A space as second name character, then a parameter whose value
    // holds the all-zero and all-ones bytes.
    line_q.delete();
    append_text("IBB0 I QZ");
    line_q.push_back(8'h00);
    line_q.push_back(8'hFF);
    send_line();
    // Order violations: reversed, repeated, and known after unknown.
    send_text("IBB0 PAx IDy");
    send_text("IBB0 IDx IDy");
    send_text("IBB0 ZZx IDy");
    // Form violations. The empty value also shows that the failure sticks
    // through the good parameter after it.
    send_text("IBB0  ID1");
    send_text("IBB0 ID  PA1");
    send_text("IBB0XID1");
    // Wrong magic with a well-formed parameter list.
    send_text("IBX0 SJ1");

    // Random headers. The long output stall comes early, and a stretch
    // without idling on either side follows later.
    random_start = bytes_sent;
    while (bytes_sent - random_start < RANDOM_BYTES) begin
      if (!hold_done && bytes_sent - random_start >= 150) begin
        hold_request = 1;
        hold_done    = 1;
      end
      quiet = (bytes_sent - random_start >= 300) && (bytes_sent - random_start < 450);
      build_random_line();
      send_line();
    end
    quiet = 0;
    in_ch.valid <= 1'b0;

    // Drain: every owed verdict must come out, and the output is then
    // watched on for anything extra.
    while (board.expected_verdicts.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d headers in %0d bytes and checked %0d verdicts",
             headers_sent, bytes_sent, board.verdicts_checked);
    $display("(%0d canonical, %0d good magic); stimulus covered edge headers,",
             board.canonical_count, board.magic_ok_count);
    $display("order and form defects, and a %0d-cycle output hold-off.", HOLD_CYCLES);
    if (board.mismatches == 0) begin
      $display("PASS post_header_canonical_checker_core");
    end else begin
      $display("FAIL post_header_canonical_checker_core");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+rtl
rtl/phcc_pkg.sv
rtl/phcc_in_if.sv
rtl/phcc_out_if.sv
rtl/phcc_step.sv
rtl/post_header_canonical_checker_core.sv
tb/post_header_canonical_checker_core_test.sv
